FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset masking.
`define KECT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("keyed event counter table assertion failed");

// Same-cycle implication built on the clocked form.
`define KECT_IMPLY(label, ante, cons) \
  `KECT_ASSERT(label, (ante) |-> (cons))

`endif

FILE: hw/rtl/kect_pkg.sv
// Shared codes and the table entry layout for the keyed event counter table.
package kect_pkg;

  // command codes
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_SNAP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_DROP    = 3'd2;
  localparam logic [2:0] ST_SNAP    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic        [31:0] key;
    logic        [31:0] count;
    logic        [63:0] arg;
    logic signed [31:0] pid;
    logic signed [31:0] tgid;
    logic signed [31:0] minor;
    logic        [31:0] major;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/kect_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/keyed_event_counter_table_top.sv
// Top level of the keyed event counter table: used flags, entry memory, walk control.
//
// The table holds TABLE_DEPTH entries in one entry memory (one read or one
// write a cycle, registered read data) with the used flags in flip-flops.
// A record walks the memory one entry a cycle and stops early when the key
// hits. A snapshot skips free entries and reads, then emits, each used
// entry in turn. A clear or an empty snapshot goes straight to its result;
// an unused command is dropped and gives no result. The result sits in an
// output register, so the walk of the next item starts while a result
// is still waiting; an item is only held up when its own result finds that
// register still full. Reset clears the used flags at once; no clearing
// pass is needed.
module keyed_event_counter_table_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_ioctl_code,
  input  logic signed [31:0] in_caller_pid,
  input  logic signed [31:0] in_caller_tgid,
  input  logic signed [31:0] in_device_minor,
  input  logic [31:0]        in_device_major,
  input  logic [63:0]        in_event_arg,
  input  logic [7:0]         in_max_records,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [31:0]        out_entry_code,
  output logic [31:0]        out_hit_count,
  output logic [63:0]        out_recent_arg,
  output logic signed [31:0] out_recent_pid,
  output logic signed [31:0] out_recent_tgid,
  output logic signed [31:0] out_last_minor,
  output logic [31:0]        out_last_major,
  output logic [6:0]         out_copied_so_far,
  output logic               out_last_of_run
);

  import kect_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REC     = 3'd1;
  localparam logic [2:0] S_REC_FIN = 3'd2;
  localparam logic [2:0] S_SNAP_RD = 3'd3;
  localparam logic [2:0] S_SNAP_EM = 3'd4;
  localparam logic [2:0] S_SIMPLE  = 3'd5;

  // control state
  logic [2:0]             state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] used_r, used_nxt;
  logic [CW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   dv_r, dv_nxt;
  logic                   have_free_r, have_free_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // working registers
  logic                   du_r, du_nxt;
  logic [IW-1:0]          d_idx_r, d_idx_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [IW-1:0]          slot_r, slot_nxt;
  logic [31:0]            cnt_r, cnt_nxt;
  logic [2:0]             res_status_r, res_status_nxt;
  logic [6:0]             n_r, n_nxt;

  // captured item
  logic [31:0]            code_r;
  logic signed [31:0]     pid_r, tgid_r, minor_r;
  logic [31:0]            major_r;
  logic [63:0]            arg_r;
  logic [7:0]             limit_r;

  // output register
  logic [2:0]             out_status_r, out_status_nxt;
  entry_t                 out_entry_r, out_entry_nxt;
  logic [6:0]             out_copied_r, out_copied_nxt;
  logic                   out_last_r, out_last_nxt;

  // memory ports
  logic                   rd_en, wr_en;
  logic [IW-1:0]          rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  entry_t                 rd_entry, wr_entry;

  logic                   accept, out_free, out_load;
  logic [IW-1:0]          cur_idx;
  logic [TABLE_DEPTH-1:0] hi_mask;
  logic                   more_used, snap_last, key_hit;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cur_idx  = scan_idx_r[IW-1:0];
  assign rd_entry = entry_t'(rd_data);
  assign key_hit  = dv_r && du_r && (rd_entry.key == code_r);

  // mark entries above the current one
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      hi_mask[k] = (k > int'(cur_idx));
    end
  end

  assign more_used = |(used_r & hi_mask);
  assign snap_last = ((8'(n_r) + 8'd1) == limit_r) || !more_used;

  // entry written back by a record
  always_comb begin
    wr_entry       = '0;
    wr_entry.key   = code_r;
    wr_entry.count = cnt_r;
    wr_entry.arg   = arg_r;
    wr_entry.pid   = pid_r;
    wr_entry.tgid  = tgid_r;
    wr_entry.minor = minor_r;
    wr_entry.major = major_r;
  end

  // sequence record, snapshot and clear
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    scan_idx_nxt   = scan_idx_r;
    dv_nxt         = 1'b0;
    du_nxt         = du_r;
    d_idx_nxt      = d_idx_r;
    have_free_nxt  = have_free_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    n_nxt          = n_r;
    rd_en          = 1'b0;
    rd_addr        = cur_idx;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_copied_nxt = out_copied_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_idx_nxt  = '0;
          have_free_nxt = 1'b0;
          n_nxt         = '0;
          case (in_cmd)
            CMD_RECORD: state_nxt = S_REC;
            CMD_SNAP: begin
              if (in_max_records == 8'd0 || used_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_SIMPLE;
              end else begin
                state_nxt = S_SNAP_RD;
              end
            end
            CMD_CLEAR: begin
              used_nxt       = '0;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_SIMPLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_REC: begin
        // issue one read a cycle and note the lowest free entry
        if (scan_idx_r < CW'(TABLE_DEPTH)) begin
          rd_en        = 1'b1;
          dv_nxt       = 1'b1;
          d_idx_nxt    = cur_idx;
          du_nxt       = used_r[cur_idx];
          scan_idx_nxt = scan_idx_r + CW'(1);
          if (!used_r[cur_idx] && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = cur_idx;
          end
        end
        // compare the entry read last cycle
        if (key_hit) begin
          slot_nxt       = d_idx_r;
          cnt_nxt        = rd_entry.count + 32'd1;
          res_status_nxt = ST_HIT;
          state_nxt      = S_REC_FIN;
        end else if (dv_r && d_idx_r == IW'(TABLE_DEPTH - 1)) begin
          slot_nxt       = free_idx_r;
          cnt_nxt        = 32'd1;
          res_status_nxt = have_free_r ? ST_NEW : ST_DROP;
          state_nxt      = S_REC_FIN;
        end
      end

      S_REC_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_copied_nxt = '0;
          out_last_nxt   = 1'b1;
          if (res_status_r == ST_DROP) begin
            out_entry_nxt     = '0;
            out_entry_nxt.key = code_r;
          end else begin
            out_entry_nxt    = wr_entry;
            wr_en            = 1'b1;
            used_nxt[slot_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_SNAP_RD: begin
        // skip free entries, read used ones
        if (scan_idx_r >= CW'(TABLE_DEPTH)) begin
          state_nxt = S_IDLE;
        end else if (used_r[cur_idx]) begin
          rd_en     = 1'b1;
          state_nxt = S_SNAP_EM;
        end else begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end

      S_SNAP_EM: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_SNAP;
          out_entry_nxt  = rd_entry;
          out_copied_nxt = n_r + 7'd1;
          out_last_nxt   = snap_last;
          n_nxt          = n_r + 7'd1;
          scan_idx_nxt   = scan_idx_r + CW'(1);
          state_nxt      = snap_last ? S_IDLE : S_SNAP_RD;
        end
      end

      S_SIMPLE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = '0;
          out_copied_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid: set on load, drop when taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      scan_idx_r  <= '0;
      dv_r        <= 1'b0;
      have_free_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      scan_idx_r  <= scan_idx_nxt;
      dv_r        <= dv_nxt;
      have_free_r <= have_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    du_r         <= du_nxt;
    d_idx_r      <= d_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    slot_r       <= slot_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_copied_r <= out_copied_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      code_r  <= in_ioctl_code;
      pid_r   <= in_caller_pid;
      tgid_r  <= in_caller_tgid;
      minor_r <= in_device_minor;
      major_r <= in_device_major;
      arg_r   <= in_event_arg;
      limit_r <= in_max_records;
    end
  end

  // entry memory
  kect_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_code    = out_entry_r.key;
  assign out_hit_count     = out_entry_r.count;
  assign out_recent_arg    = out_entry_r.arg;
  assign out_recent_pid    = out_entry_r.pid;
  assign out_recent_tgid   = out_entry_r.tgid;
  assign out_last_minor    = out_entry_r.minor;
  assign out_last_major    = out_entry_r.major;
  assign out_copied_so_far = out_copied_r;
  assign out_last_of_run   = out_last_r;

endmodule

FILE: hw/rtl/kect_checker.sv
// Port-level assertions for the keyed event counter table and their bind.
`include "assert_macros.svh"

module kect_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic [31:0]        out_entry_code,
  input logic [31:0]        out_hit_count,
  input logic [6:0]         out_copied_so_far,
  input logic               out_last_of_run
);

  import kect_pkg::*;

  // hold a stalled result
  `KECT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_entry_code) && $stable(out_hit_count)))

  // a freshly claimed entry starts its count at one
  `KECT_IMPLY(a_new_count, out_valid && out_status == ST_NEW, out_hit_count == 32'd1)

  // only snapshot entries carry a running number
  `KECT_IMPLY(a_copied, out_valid, (out_status == ST_SNAP) == (out_copied_so_far != 7'd0))

  // single-result items always close their run
  `KECT_IMPLY(a_single_last, out_valid && out_status != ST_SNAP, out_last_of_run)

endmodule

bind keyed_event_counter_table_top kect_checker u_kect_checker (.*);
